[rtl/core/assembly_source_tokenizer_defines.svh]
// Assertion macros shared by the tokenizer modules.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AST_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AST_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ast_pkg.sv]
// Types, constants and helper functions of the assembly source tokenizer.
package ast_pkg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [5:0]  keyword_code;
        logic [31:0] number_value;
        logic [7:0]  text_byte;
        logic [23:0] line_number;
        logic        hex_error;
        logic        last_of_run;
    } t_out_item;

    // Results handed from the scanner to the result queue in one cycle.
    typedef struct packed {
        logic [1:0] n;
        t_out_item  item0;
        t_out_item  item1;
    } t_res_push;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_IDENT = 4'd1,
        MODE_ZERO  = 4'd2,
        MODE_DEC   = 4'd3,
        MODE_OCT   = 4'd4,
        MODE_HEXX  = 4'd5,
        MODE_HEX   = 4'd6,
        MODE_STR   = 4'd7,
        MODE_ESC   = 4'd8,
        MODE_COMM  = 4'd9
    } t_mode;

    localparam logic [2:0] KIND_IDENT_CHAR = 3'd0;
    localparam logic [2:0] KIND_IDENT_DONE = 3'd1;
    localparam logic [2:0] KIND_INTEGER    = 3'd2;
    localparam logic [2:0] KIND_STR_CHAR   = 3'd3;
    localparam logic [2:0] KIND_STR_DONE   = 3'd4;
    localparam logic [2:0] KIND_COMMENT    = 3'd5;
    localparam logic [2:0] KIND_SINGLE     = 3'd6;
    localparam logic [2:0] KIND_END        = 3'd7;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_BSL   = 8'h5c;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    localparam logic [23:0] FIRST_LINE_RESET = 24'd1;
    localparam logic [2:0]  IDENT_MAX_KW     = 3'd5;
    localparam logic [2:0]  IDENT_SAT        = 3'd6;

    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int unsigned KW_COUNT  = 42;

    // Keyword spellings packed big-endian into 40 bits, in code order 1..42.
    localparam logic [39:0] KW_SPELL [KW_COUNT] = '{
        40'h0064617461, 40'h00636f6465, 40'h0000696e74, 40'h006c6f6164,
        40'h73746f7265, 40'h00006c6561, 40'h0068616c74, 40'h6c6162656c,
        40'h00006a6d70, 40'h0000006a62, 40'h0000006a65, 40'h00006a6e65,
        40'h0000006a67, 40'h00006a6765, 40'h00006a6265, 40'h0063616c6c,
        40'h0000726574, 40'h0070757368, 40'h0000706f70, 40'h00006d6f76,
        40'h000000696e, 40'h00006f7574, 40'h00006e6567, 40'h006c6f6f70,
        40'h0000616464, 40'h0000737562, 40'h00006d756c, 40'h0000646976,
        40'h00006d6f64, 40'h0000636d70, 40'h000073686c, 40'h0000736872,
        40'h000073616c, 40'h0000736172, 40'h000073726c, 40'h0000737272,
        40'h0000766172, 40'h0000006673, 40'h0000006773, 40'h0069726574,
        40'h0000636c69, 40'h0000737469
    };

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return b >= "0" && b <= "7";
    endfunction

    // Bit 4 flags a hex digit, bits 3:0 carry its value.
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(b)) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            // Letters a..f and A..F share low bits 1..6.
            r = {1'b1, 4'(b[2:0] + 3'd1) + 4'd8};
        end
        return r;
    endfunction

    function automatic t_out_item make_res(input logic [2:0] kind, input logic [5:0] kw,
                                           input logic [31:0] num, input logic [7:0] txt,
                                           input logic [23:0] line, input logic herr);
        t_out_item r;
        r.token_kind   = kind;
        r.keyword_code = kw;
        r.number_value = num;
        r.text_byte    = txt;
        r.line_number  = line;
        r.hex_error    = herr;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

[rtl/core/ast_kw_match.sv]
// Keyword lookup: compares the identifier prefix with every keyword in parallel.
module ast_kw_match (
    input  logic [39:0] i_prefix,
    input  logic [2:0]  i_len,
    output logic [5:0]  o_code
);
    import ast_pkg::*;

    always_comb begin
        o_code = 6'd0;
        // Spellings are distinct, so at most one compare can hit.
        for (int i = 0; i < KW_COUNT; i++) begin
            if (i_prefix == KW_SPELL[i]) begin
                o_code = o_code | 6'(i + 1);
            end
        end
        if (i_len == 3'd0 || i_len > IDENT_MAX_KW) begin
            o_code = 6'd0;
        end
    end

endmodule

[rtl/core/ast_out_fifo.sv]
// Result queue: takes up to two results a cycle and hands out one a cycle while i_out_ready is high.
module ast_out_fifo (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  ast_pkg::t_res_push       i_push,
    output logic                     o_room,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output ast_pkg::t_out_item       o_out_item
);
    import ast_pkg::*;

    t_out_item          r_slot [Q_DEPTH];
    t_out_item          n_slot [Q_DEPTH];
    t_out_item          shifted [Q_DEPTH];
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic [Q_CNT_W-1:0] base;
    logic               pop;

    assign pop         = (r_count != '0) && i_out_ready;
    assign o_out_valid = (r_count != '0);
    assign o_out_item  = r_slot[0];
    assign o_room      = (r_count <= Q_CNT_W'(Q_DEPTH - 2));

    always_comb begin
        for (int k = 0; k < Q_DEPTH - 1; k++) begin
            shifted[k] = r_slot[k + 1];
        end
        shifted[Q_DEPTH-1] = r_slot[Q_DEPTH-1];

        base    = r_count - Q_CNT_W'(pop);
        n_count = base + Q_CNT_W'(i_push.n);
        for (int k = 0; k < Q_DEPTH; k++) begin
            n_slot[k] = pop ? shifted[k] : r_slot[k];
            if (i_push.n != 2'd0 && base == Q_CNT_W'(k)) begin
                n_slot[k] = i_push.item0;
            end
            if (i_push.n == 2'd2 && base + Q_CNT_W'(1) == Q_CNT_W'(k)) begin
                n_slot[k] = i_push.item1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < Q_DEPTH; k++) begin
            r_slot[k] <= n_slot[k];
        end
    end

`include "assembly_source_tokenizer_defines.svh"

    `AST_ASSERT_NOW(a_count_bound, 1'b1, r_count <= Q_CNT_W'(Q_DEPTH), "result queue overfilled")
    `AST_ASSERT_NOW(a_push_room, i_push.n != 2'd0, o_room, "results pushed without room")
    `AST_ASSERT_NEXT(a_pop_only, pop && i_push.n == 2'd0, r_count == $past(r_count) - Q_CNT_W'(1), "queue count did not drop on pop")

endmodule

[rtl/core/ast_scan.sv]
// Scanner: input register and the per-byte state update that forms up to two results.
module ast_scan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ast_pkg::t_in_item  i_in_item,
    input  logic [23:0]        i_first_line,
    input  logic               i_room,
    output ast_pkg::t_res_push o_push
);
    import ast_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_item;
    t_mode       r_mode, n_mode;
    logic [31:0] r_acc, n_acc;
    logic [39:0] r_prefix, n_prefix;
    logic [2:0]  r_len, n_len;
    logic [23:0] r_line, n_line;

    logic        fire;
    logic [7:0]  b;
    logic [5:0]  kw_code;
    logic [4:0]  hv;
    logic [31:0] acc_dec, acc_oct, acc_hex;
    logic [7:0]  esc_byte;

    // Between-token handling of the current byte.
    t_mode       id_mode;
    logic        id_nl;
    logic        id_ident;
    logic        id_acc_ld;
    logic [31:0] id_acc;
    logic        id_res_v;
    t_out_item   id_res;

    // First result comes from the mode itself, the second from the idle path or the end-of-input marker.
    logic        a_v, b_v;
    t_out_item   a_res, b_res;
    logic        use_idle;

    assign fire       = r_in_valid && i_room;
    assign o_in_ready = !r_in_valid || fire;
    assign b          = r_in_item.source_byte;
    assign hv         = hex_val(b);
    assign acc_dec    = {r_acc[28:0], 3'b000} + {r_acc[30:0], 1'b0} + {28'd0, b[3:0]};
    assign acc_oct    = {r_acc[28:0], b[2:0]};
    assign acc_hex    = {r_acc[27:0], hv[3:0]};

    ast_kw_match u_kw (
        .i_prefix (r_prefix),
        .i_len    (r_len),
        .o_code   (kw_code)
    );

    always_comb begin
        case (b)
            "n":     esc_byte = CH_NL;
            "t":     esc_byte = CH_TAB;
            "r":     esc_byte = CH_CR;
            default: esc_byte = b;
        endcase
    end

    always_comb begin
        id_mode   = MODE_IDLE;
        id_nl     = 1'b0;
        id_ident  = 1'b0;
        id_acc_ld = 1'b0;
        id_acc    = 32'd0;
        id_res_v  = 1'b0;
        id_res    = make_res(KIND_IDENT_CHAR, 6'd0, 32'd0, b, r_line, 1'b0);
        if (b == CH_SPACE || b == CH_TAB) begin
            id_mode = MODE_IDLE;
        end else if (b == CH_NL) begin
            id_nl = 1'b1;
        end else if (is_alpha(b)) begin
            id_mode  = MODE_IDENT;
            id_ident = 1'b1;
            id_res_v = 1'b1;
        end else if (b == "0") begin
            id_mode   = MODE_ZERO;
            id_acc_ld = 1'b1;
        end else if (is_digit(b)) begin
            id_mode   = MODE_DEC;
            id_acc_ld = 1'b1;
            id_acc    = {28'd0, b[3:0]};
        end else if (b == CH_QUOTE) begin
            id_mode = MODE_STR;
        end else if (b == CH_SEMI) begin
            id_mode = MODE_COMM;
        end else begin
            id_res_v = 1'b1;
            id_res   = make_res(KIND_SINGLE, 6'd0, 32'd0, b, r_line, 1'b0);
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_prefix = r_prefix;
        n_len    = r_len;
        n_line   = r_line;
        a_v      = 1'b0;
        b_v      = 1'b0;
        a_res    = make_res(KIND_INTEGER, 6'd0, r_acc, 8'd0, r_line, 1'b0);
        b_res    = id_res;
        use_idle = 1'b0;

        if (r_in_item.end_of_input) begin
            a_v = 1'b1;
            case (r_mode)
                MODE_IDENT: a_res = make_res(KIND_IDENT_DONE, kw_code, 32'd0, 8'd0, r_line, 1'b0);
                MODE_ZERO, MODE_DEC, MODE_OCT, MODE_HEX: a_res.number_value = r_acc;
                MODE_HEXX: a_res.number_value = 32'd0;
                MODE_STR, MODE_ESC: a_res = make_res(KIND_STR_DONE, 6'd0, 32'd0, 8'd0, r_line, 1'b0);
                MODE_COMM: a_res = make_res(KIND_COMMENT, 6'd0, 32'd0, 8'd0, r_line, 1'b0);
                default: a_v = 1'b0;
            endcase
            b_v      = 1'b1;
            b_res    = make_res(KIND_END, 6'd0, 32'd0, 8'd0, r_line, 1'b0);
            n_mode   = MODE_IDLE;
            n_acc    = 32'd0;
            n_prefix = 40'd0;
            n_len    = 3'd0;
            n_line   = i_first_line;
        end else begin
            case (r_mode)
                MODE_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
                        if (r_len < IDENT_MAX_KW) begin
                            n_prefix = {r_prefix[31:0], b};
                        end
                        if (r_len < IDENT_SAT) begin
                            n_len = r_len + 3'd1;
                        end
                        a_v   = 1'b1;
                        a_res = make_res(KIND_IDENT_CHAR, 6'd0, 32'd0, b, r_line, 1'b0);
                    end else begin
                        a_v      = 1'b1;
                        a_res    = make_res(KIND_IDENT_DONE, kw_code, 32'd0, 8'd0, r_line, 1'b0);
                        use_idle = 1'b1;
                    end
                end
                MODE_ZERO: begin
                    if (b == "x" || b == "X") begin
                        n_mode = MODE_HEXX;
                    end else if (is_octal(b)) begin
                        n_mode = MODE_OCT;
                        n_acc  = {29'd0, b[2:0]};
                    end else begin
                        a_v      = 1'b1;
                        n_acc    = 32'd0;
                        use_idle = 1'b1;
                    end
                end
                MODE_DEC: begin
                    if (is_digit(b)) begin
                        n_acc = acc_dec;
                    end else begin
                        a_v      = 1'b1;
                        n_acc    = 32'd0;
                        use_idle = 1'b1;
                    end
                end
                MODE_OCT: begin
                    if (is_octal(b)) begin
                        n_acc = acc_oct;
                    end else begin
                        a_v      = 1'b1;
                        n_acc    = 32'd0;
                        use_idle = 1'b1;
                    end
                end
                MODE_HEXX: begin
                    if (hv[4]) begin
                        n_mode = MODE_HEX;
                        n_acc  = {28'd0, hv[3:0]};
                    end else begin
                        a_v      = 1'b1;
                        a_res    = make_res(KIND_INTEGER, 6'd0, 32'd0, 8'd0, r_line, 1'b1);
                        n_acc    = 32'd0;
                        use_idle = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (hv[4]) begin
                        n_acc = acc_hex;
                    end else begin
                        a_v      = 1'b1;
                        n_acc    = 32'd0;
                        use_idle = 1'b1;
                    end
                end
                MODE_STR: begin
                    if (b == CH_QUOTE) begin
                        a_v    = 1'b1;
                        a_res  = make_res(KIND_STR_DONE, 6'd0, 32'd0, 8'd0, r_line, 1'b0);
                        n_mode = MODE_IDLE;
                    end else if (b == CH_BSL) begin
                        n_mode = MODE_ESC;
                    end else begin
                        a_v   = 1'b1;
                        a_res = make_res(KIND_STR_CHAR, 6'd0, 32'd0, b, r_line, 1'b0);
                    end
                end
                MODE_ESC: begin
                    a_v    = 1'b1;
                    a_res  = make_res(KIND_STR_CHAR, 6'd0, 32'd0, esc_byte, r_line, 1'b0);
                    n_mode = MODE_STR;
                end
                MODE_COMM: begin
                    if (b == CH_NL) begin
                        a_v    = 1'b1;
                        a_res  = make_res(KIND_COMMENT, 6'd0, 32'd0, 8'd0, r_line, 1'b0);
                        n_line = r_line + 24'd1;
                        n_mode = MODE_IDLE;
                    end
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase

            if (use_idle) begin
                n_mode = id_mode;
                b_v    = id_res_v;
                if (id_nl) begin
                    n_line = r_line + 24'd1;
                end
                if (id_ident) begin
                    n_prefix = {32'd0, b};
                    n_len    = 3'd1;
                end
                if (id_acc_ld) begin
                    n_acc = id_acc;
                end
            end
        end
    end

    always_comb begin
        o_push.n     = 2'd0;
        o_push.item0 = a_res;
        o_push.item1 = b_res;
        if (fire) begin
            if (a_v && b_v) begin
                o_push.n = 2'd2;
                o_push.item1.last_of_run = 1'b1;
            end else if (a_v) begin
                o_push.n = 2'd1;
                o_push.item0.last_of_run = 1'b1;
            end else if (b_v) begin
                o_push.n     = 2'd1;
                o_push.item0 = b_res;
                o_push.item0.last_of_run = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_acc      <= 32'd0;
            r_prefix   <= 40'd0;
            r_len      <= 3'd0;
            r_line     <= FIRST_LINE_RESET;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_mode   <= n_mode;
                r_acc    <= n_acc;
                r_prefix <= n_prefix;
                r_len    <= n_len;
                r_line   <= n_line;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

`include "assembly_source_tokenizer_defines.svh"

    `AST_ASSERT_NEXT(a_end_resets, fire && r_in_item.end_of_input, r_mode == MODE_IDLE && r_line == $past(i_first_line), "end of input did not restore idle state")
    `AST_ASSERT_NOW(a_ident_len, r_mode == MODE_IDENT, r_len != 3'd0, "identifier mode with empty length")
    `AST_ASSERT_NOW(a_last_flag, o_push.n == 2'd2, o_push.item1.last_of_run && !o_push.item0.last_of_run, "last-of-run flag misplaced")

endmodule

[rtl/core/assembly_source_tokenizer.sv]
// Top level of the assembly source tokenizer: configuration register, scanner and result queue.
// Accepts one source byte (or an end-of-input marker) per cycle and yields zero, one or two
// tokens for it, which reach o_out_item through the result queue. The scanner takes a byte
// every cycle while its four-entry result queue has room for two results, and the output port
// delivers one result per cycle while i_out_ready is high, so a stream whose bytes mostly close
// or emit at most one token runs at one byte per cycle, while bytes that yield two tokens fill
// the queue faster than it drains. Register 0 at paddr 0 to 3 holds the first line
// number (24 bits, reset 1), loaded into the line counter at reset and after end of input.
module assembly_source_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ast_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ast_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ast_pkg::*;

    logic [23:0] r_first_line;
    logic        room;
    t_res_push   push;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == 1'b0);
    assign prdata  = reg_sel ? {8'd0, r_first_line} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_line <= FIRST_LINE_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_first_line <= pwdata[23:0];
        end
    end

    ast_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_item    (i_in_item),
        .i_first_line (r_first_line),
        .i_room       (room),
        .o_push       (push)
    );

    ast_out_fifo u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
